### src/host_filter_table_top_defines.svh
// Assertion macros for the host filter table checker.
// Needs clk and arst_n in the scope where a macro is used.
`ifndef HOST_FILTER_TABLE_TOP_DEFINES_SVH
`define HOST_FILTER_TABLE_TOP_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define HFT_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HFT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/hft_pkg.sv
// Shared types and constants for the host filter table.
// No dependencies.
`timescale 1ns / 1ps

package hft_pkg;

	localparam int ADDR_W      = 32;
	localparam int IN_TDATA_W  = 104;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 8;

	localparam logic [IN_TUSER_W-1:0] OP_SET   = 2'd0;
	localparam logic [IN_TUSER_W-1:0] OP_CLEAR = 2'd1;
	localparam logic [IN_TUSER_W-1:0] OP_CHECK = 2'd2;

	// One table entry as held in the memory.
	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic              flag;
	} entry_t;

	// Result beat, changed in the lowest bit.
	typedef struct packed {
		logic full_res;
		logic show;
		logic changed;
	} res_t;

endpackage

### src/hft_mem.sv
// Entry storage: one write port, one registered read port.
// Depends on hft_pkg.
`timescale 1ns / 1ps

module hft_mem #(
	parameter int DEPTH = 16,
	parameter int IDX_W = 4
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [IDX_W-1:0]     waddr,
	input  hft_pkg::entry_t      wdata,
	input  logic                 re,
	input  logic [IDX_W-1:0]     raddr,
	output hft_pkg::entry_t      rdata
);

	hft_pkg::entry_t mem_q [DEPTH];
	hft_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

### src/hft_cmp.sv
// Shared address comparator used by every scan step.
// Depends on hft_pkg.
`timescale 1ns / 1ps

module hft_cmp (
	input  logic [hft_pkg::ADDR_W-1:0] entry_addr,
	input  logic [hft_pkg::ADDR_W-1:0] key_a,
	input  logic [hft_pkg::ADDR_W-1:0] key_b,
	output logic                       match
);

	assign match = (entry_addr == key_a) || (entry_addr == key_b);

endmodule

### src/host_filter_table_top.sv
// Host filter table top level: sequencer, entry count and output register.
// Depends on hft_pkg, hft_mem and hft_cmp.
//
// channel   dir  beat contents
// s_axis    in   tuser[1:0] opcode; tdata key_addr, on_off, local_addr, foreign_addr
// m_axis    out  tdata changed, show, full_res
//
// A set or check reads the n entries held one per cycle through the single read
// port of the entry memory and compares each one as it leaves the read register;
// a scan stops on the first match. A new beat is taken only once the last one is
// done. The entry count resets to zero; entries are not cleared. A result waits
// in the output register while the next beat is accepted and processed; the next
// result then holds the sequencer until it is taken.
`timescale 1ns / 1ps

module host_filter_table_top #(
	parameter int MAX_HOSTS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	// [31:0] key_addr, [32] on_off, [64:33] local_addr, [96:65] foreign_addr
	input  logic [hft_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
	// [1:0] opcode
	input  logic [hft_pkg::IN_TUSER_W-1:0]     s_axis_tuser,
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] changed, [1] show, [2] full_res
	output logic [hft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	localparam int CNT_W = $clog2(MAX_HOSTS + 1);
	localparam int IDX_W = (MAX_HOSTS > 1) ? $clog2(MAX_HOSTS) : 1;
	localparam int AW    = hft_pkg::ADDR_W;
	localparam int PAD_W = hft_pkg::OUT_TDATA_W - $bits(hft_pkg::res_t);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_HOSTS);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SCAN = 3'b010,
		ST_DONE = 3'b100
	} st_t;

	st_t                               state_q;
	logic [CNT_W-1:0]                  count_q;
	logic [CNT_W-1:0]                  idx_q;
	logic                              rvalid_s1;
	logic [IDX_W-1:0]                  idx_s1;
	logic                              out_valid_q;
	hft_pkg::res_t                     out_q;
	hft_pkg::res_t                     res_q;
	hft_pkg::res_t                     res_in;
	hft_pkg::res_t                     res_fin;

	logic [hft_pkg::IN_TUSER_W-1:0]    op_q;
	logic [AW-1:0]                     key_q;
	logic                              flag_q;
	logic [AW-1:0]                     laddr_q;
	logic [AW-1:0]                     faddr_q;

	logic                              in_beat;
	logic                              issue;
	logic                              hit;
	logic                              finish;
	logic                              full;
	logic                              match;
	logic                              is_check;
	logic                              out_load;
	logic [AW-1:0]                     cmp_a;
	logic [AW-1:0]                     cmp_b;
	logic                              mem_we;
	logic [IDX_W-1:0]                  mem_waddr;
	hft_pkg::entry_t                   mem_wdata;
	hft_pkg::entry_t                   mem_rdata;

	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_beat       = s_axis_tvalid && s_axis_tready;

	assign is_check = (op_q == hft_pkg::OP_CHECK);
	assign cmp_a    = is_check ? laddr_q : key_q;
	assign cmp_b    = is_check ? faddr_q : key_q;

	assign issue  = (state_q == ST_SCAN) && (idx_q < count_q);
	assign hit    = rvalid_s1 && match;
	assign finish = (state_q == ST_SCAN) && (hit || (!issue && !rvalid_s1));
	assign full   = (count_q == CNT_MAX);

	assign out_load = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready);

	// A set overwrites the matching entry in place, or appends at the tail if the table is not full.
	assign mem_we         = finish && (op_q == hft_pkg::OP_SET) && (hit || !full);
	assign mem_waddr      = hit ? idx_s1 : count_q[IDX_W-1:0];
	assign mem_wdata.addr = key_q;
	assign mem_wdata.flag = flag_q;

	hft_mem #(
		.DEPTH (MAX_HOSTS),
		.IDX_W (IDX_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (issue),
		.raddr (idx_q[IDX_W-1:0]),
		.rdata (mem_rdata)
	);

	hft_cmp u_cmp (
		.entry_addr (mem_rdata.addr),
		.key_a      (cmp_a),
		.key_b      (cmp_b),
		.match      (match)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rvalid_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			rvalid_s1   <= issue && !finish;
			out_valid_q <= out_load || (out_valid_q && !m_axis_tready);
			case (state_q)
				ST_IDLE: begin
					if (in_beat) begin
						idx_q <= '0;
						if (s_axis_tuser == hft_pkg::OP_SET ||
						    s_axis_tuser == hft_pkg::OP_CHECK) begin
							state_q <= ST_SCAN;
						end else begin
							state_q <= ST_DONE;
							if (s_axis_tuser == hft_pkg::OP_CLEAR) begin
								count_q <= '0;
							end
						end
					end
				end
				ST_SCAN: begin
					if (issue) begin
						idx_q <= idx_q + CNT_W'(1);
					end
					if (finish) begin
						state_q <= ST_DONE;
						if (op_q == hft_pkg::OP_SET && !hit && !full) begin
							count_q <= count_q + CNT_W'(1);
						end
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		res_in         = '0;
		res_in.changed = (s_axis_tuser == hft_pkg::OP_CLEAR) && (count_q != '0);
		res_fin        = '0;
		if (is_check) begin
			res_fin.show = hit ? mem_rdata.flag : 1'b1;
		end else begin
			res_fin.changed  = !hit && !full;
			res_fin.full_res = !hit && full;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= idx_q[IDX_W-1:0];
		if (in_beat) begin
			op_q    <= s_axis_tuser;
			key_q   <= s_axis_tdata[AW-1:0];
			flag_q  <= s_axis_tdata[AW];
			laddr_q <= s_axis_tdata[2*AW:AW+1];
			faddr_q <= s_axis_tdata[3*AW:2*AW+1];
		end
		if (finish) begin
			res_q <= res_fin;
		end else if (in_beat) begin
			res_q <= res_in;
		end
		if (out_load) begin
			out_q <= res_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_q};

endmodule

### src/hft_chk.sv
// Port-level checker for the host filter table, bound to the top level.
// Depends on hft_pkg and host_filter_table_top_defines.svh.
`timescale 1ns / 1ps
`include "host_filter_table_top_defines.svh"

module hft_chk (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               s_axis_tvalid,
	input logic                               s_axis_tready,
	input logic                               m_axis_tvalid,
	input logic                               m_axis_tready,
	input logic [hft_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);

	// A stalled result beat must not change.
	`HFT_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

	// Each opcode reports through at most one result bit, and padding stays zero.
	`HFT_ASSERT_SAME(a_one_flag, m_axis_tvalid, ($countones(m_axis_tdata[2:0]) <= 1) && (m_axis_tdata[7:3] == 5'd0), "result beat has more than one flag set")

	// No command is accepted in the cycle right after another is accepted.
	`HFT_ASSERT_NEXT(a_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input accepted back to back")

endmodule

bind host_filter_table_top hft_chk u_hft_chk (.*);

### test/hft_checker.sv
// Checker for the host filter table: watches both stream channels, predicts each
// result beat from its own copy of the table and compares. Depends on hft_pkg.
`timescale 1ns / 1ps

module hft_checker #(
	parameter int MAX_HOSTS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [hft_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic [hft_pkg::IN_TUSER_W-1:0]  s_tuser,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [hft_pkg::OUT_TDATA_W-1:0] m_tdata,
	output int                              errors,
	output int                              pending
);

	logic [hft_pkg::ADDR_W-1:0] host_addr [MAX_HOSTS];
	logic                       host_flag [MAX_HOSTS];
	int                         host_count;
	hft_pkg::res_t              result_q [$];

	// Applies one command to the shadow table and returns the result beat it causes.
	function automatic hft_pkg::res_t filter_step(input logic [hft_pkg::IN_TUSER_W-1:0] op,
			input logic [hft_pkg::ADDR_W-1:0] key, input logic flag,
			input logic [hft_pkg::ADDR_W-1:0] laddr, input logic [hft_pkg::ADDR_W-1:0] faddr);
		hft_pkg::res_t r;
		bit   hit;
		int   idx;
		r = '0;
		hit = 1'b0;
		case (op)
			hft_pkg::OP_SET: begin
				for (idx = 0; idx < host_count && !hit; idx++) begin
					if (host_addr[idx] == key) begin
						host_flag[idx] = flag;
						hit = 1'b1;
					end
				end
				if (!hit) begin
					if (host_count < MAX_HOSTS) begin
						host_addr[host_count] = key;
						host_flag[host_count] = flag;
						host_count++;
						r.changed = 1'b1;
					end else begin
						r.full_res = 1'b1;
					end
				end
			end
			hft_pkg::OP_CLEAR: begin
				r.changed = (host_count > 0);
				host_count = 0;
			end
			hft_pkg::OP_CHECK: begin
				// The first entry in insertion order wins, whichever address it matches.
				r.show = 1'b1;
				for (idx = 0; idx < host_count && !hit; idx++) begin
					if (host_addr[idx] == laddr || host_addr[idx] == faddr) begin
						r.show = host_flag[idx];
						hit = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic want, input logic got);
		if (got !== want) begin
			errors++;
			$display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		hft_pkg::res_t got;
		hft_pkg::res_t want;
		if (!arst_n) begin
			host_count = 0;
			result_q.delete();
			pending = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got = hft_pkg::res_t'(m_tdata[2:0]);
				if (result_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result beat, expected none, actual %b",
						$time, m_tdata);
				end else begin
					want = result_q.pop_front();
					check_field("changed", want.changed, got.changed);
					check_field("show", want.show, got.show);
					check_field("full_res", want.full_res, got.full_res);
				end
			end
			if (s_tvalid && s_tready)
				result_q.push_back(filter_step(s_tuser, s_tdata[31:0], s_tdata[32],
					s_tdata[64:33], s_tdata[96:65]));
			pending = result_q.size();
		end
	end

endmodule

### test/tb_host_filter_table_top.sv
// Testbench top for host_filter_table_top: drives command beats with bursty timing
// and a stalling receiver, and gives the verdict. Depends on hft_pkg and hft_checker.
`timescale 1ns / 1ps

module tb_host_filter_table_top;

	localparam int MAX_HOSTS    = 16;
	localparam int RANDOM_BEATS = 830;
	localparam int POOL_SIZE    = 24;
	localparam int LONG_HOLD    = 400;

	localparam logic [hft_pkg::IN_TUSER_W-1:0] OP_UNUSED = 2'd3;

	localparam int RX_ALWAYS = 0;
	localparam int RX_RANDOM = 1;
	localparam int RX_RUNS   = 2;
	localparam int RX_HEAVY  = 3;

	logic                            clk;
	logic                            arst_n;
	logic                            s_axis_tvalid;
	logic                            s_axis_tready;
	logic [hft_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
	logic [hft_pkg::IN_TUSER_W-1:0]  s_axis_tuser;
	logic                            m_axis_tvalid;
	logic                            m_axis_tready;
	logic [hft_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

	int errors;
	int pending;
	int rx_mode;
	bit hold_go;
	bit hold_done;
	int burst_left;
	int max_gap;

	logic [hft_pkg::ADDR_W-1:0] addr_pool [POOL_SIZE];

	host_filter_table_top #(
		.MAX_HOSTS(MAX_HOSTS)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.s_axis_tuser (s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata)
	);

	hft_checker #(
		.MAX_HOSTS(MAX_HOSTS)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.s_tdata (s_axis_tdata),
		.s_tuser (s_axis_tuser),
		.m_tvalid(m_axis_tvalid),
		.m_tready(m_axis_tready),
		.m_tdata (m_axis_tdata),
		.errors  (errors),
		.pending (pending)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("host_filter_table_top test failed");
		$finish;
	end

	// Offers one beat and returns once it is taken; the burst bookkeeping decides
	// whether a gap follows.
	task automatic send_beat(input logic [hft_pkg::IN_TUSER_W-1:0] op,
			input logic [hft_pkg::ADDR_W-1:0] key, input logic flag,
			input logic [hft_pkg::ADDR_W-1:0] laddr, input logic [hft_pkg::ADDR_W-1:0] faddr);
		int gap;
		@(negedge clk);
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'd0, faddr, laddr, flag, key};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap = (max_gap == 0) ? 0 : $urandom_range(1, max_gap);
			if (gap > 0) begin
				@(negedge clk) s_axis_tvalid <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	endtask

	task automatic drain_results();
		@(negedge clk) s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// Mostly addresses from a small pool, so that sets hit existing entries and
	// checks find matches; the rest are arbitrary.
	function automatic logic [hft_pkg::ADDR_W-1:0] pick_addr();
		if ($urandom_range(0, 99) < 85)
			return addr_pool[$urandom_range(0, POOL_SIZE - 1)];
		return $urandom;
	endfunction

	task automatic random_command(input int clear_pct);
		int r;
		logic [hft_pkg::IN_TUSER_W-1:0] op;
		r = $urandom_range(0, 99);
		if (r < clear_pct)
			op = hft_pkg::OP_CLEAR;
		else if (r < clear_pct + 4)
			op = OP_UNUSED;
		else if (r < clear_pct + 52)
			op = hft_pkg::OP_SET;
		else
			op = hft_pkg::OP_CHECK;
		send_beat(op, pick_addr(), 1'($urandom_range(0, 1)), pick_addr(), pick_addr());
	endtask

	// Receiver: owns tready, including the one long hold-off.
	initial begin
		int run;
		m_axis_tready = 1'b0;
		run = 0;
		forever begin
			@(negedge clk);
			if (hold_go && !hold_done) begin
				m_axis_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				hold_done = 1'b1;
			end else begin
				case (rx_mode)
					RX_ALWAYS: m_axis_tready <= 1'b1;
					RX_RANDOM: m_axis_tready <= ($urandom_range(0, 99) >= 30);
					RX_RUNS: begin
						if (run == 0) begin
							m_axis_tready <= !m_axis_tready;
							run = $urandom_range(1, 12);
						end else begin
							run--;
						end
					end
					default: m_axis_tready <= ($urandom_range(0, 99) >= 70);
				endcase
			end
		end
	end

	initial begin
		int i;
		int phase;
		logic [hft_pkg::ADDR_W-1:0] far_addr;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = hft_pkg::OP_SET;
		rx_mode = RX_ALWAYS;
		hold_go = 1'b0;
		hold_done = 1'b0;
		burst_left = 0;
		max_gap = 0;
		addr_pool[0] = 32'h0000_0000;
		addr_pool[1] = 32'hFFFF_FFFF;
		for (i = 2; i < POOL_SIZE; i++)
			addr_pool[i] = $urandom;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Directed: empty table, unused opcode, extreme addresses, overwrite,
		// first-match order, filling to capacity and clearing.
		far_addr = $urandom;
		send_beat(hft_pkg::OP_CLEAR, 32'h0, 1'b0, 32'h0, 32'h0);
		send_beat(hft_pkg::OP_CHECK, 32'h0, 1'b0, 32'h0, 32'hFFFF_FFFF);
		send_beat(OP_UNUSED, $urandom, 1'b1, $urandom, $urandom);
		send_beat(hft_pkg::OP_SET, 32'h0000_0000, 1'b0, 32'h0, 32'h0);
		send_beat(hft_pkg::OP_SET, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_beat(hft_pkg::OP_CHECK, 32'h0, 1'b1, 32'h0000_0000, far_addr);
		send_beat(hft_pkg::OP_CHECK, 32'h0, 1'b0, far_addr, 32'hFFFF_FFFF);
		send_beat(hft_pkg::OP_SET, 32'h0000_0000, 1'b1, 32'h0, 32'h0);
		send_beat(hft_pkg::OP_SET, 32'hFFFF_FFFF, 1'b0, 32'h0, 32'h0);
		// Local hits the second entry, foreign the first: the first entry decides.
		send_beat(hft_pkg::OP_CHECK, 32'h0, 1'b0, 32'hFFFF_FFFF, 32'h0000_0000);
		for (i = 2; i < MAX_HOSTS; i++)
			send_beat(hft_pkg::OP_SET, addr_pool[i], i[0], 32'h0, 32'h0);
		send_beat(hft_pkg::OP_SET, far_addr ^ 32'h5A5A_A5A5, 1'b1, 32'h0, 32'h0);
		send_beat(hft_pkg::OP_SET, addr_pool[MAX_HOSTS - 1], 1'b1, 32'h0, 32'h0);
		send_beat(hft_pkg::OP_CHECK, 32'h0, 1'b0, far_addr, addr_pool[MAX_HOSTS - 1]);
		send_beat(hft_pkg::OP_CLEAR, 32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		drain_results();

		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin
					max_gap = 0;
					rx_mode = RX_ALWAYS;
				end
				1: begin
					max_gap = 6;
					rx_mode = RX_RANDOM;
					// The receiver holds off while beats keep coming.
					hold_go = 1'b1;
				end
				2: begin
					max_gap = 15;
					rx_mode = RX_RUNS;
				end
				default: begin
					max_gap = 3;
					rx_mode = RX_HEAVY;
				end
			endcase
			for (i = 0; i < RANDOM_BEATS / 4; i++)
				random_command(phase == 0 ? 2 : phase == 1 ? 6 : phase == 2 ? 1 : 10);
			drain_results();
		end

		repeat (MAX_HOSTS + 4) @(negedge clk);
		if (errors == 0)
			$display("host_filter_table_top test passed");
		else
			$display("host_filter_table_top test failed");
		$finish;
	end

endmodule
